/* src/nearest_target_radial_acceleration_core_defines.svh */
// Assertion macros for the nearest-target radial acceleration core.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef NEAREST_TARGET_RADIAL_ACCELERATION_CORE_DEFINES_SVH
`define NEAREST_TARGET_RADIAL_ACCELERATION_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTRA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ntra_pkg.sv */
// Package for the nearest-target radial acceleration core.
// Holds the fixed field widths, fixed-point constants and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ntra_pkg;

  localparam int NUM_TGT   = 3;
  localparam int TGT_IW    = 2;
  localparam int COORD_W   = 16;
  localparam int SQ_W      = 32;
  localparam int DIST_W    = 16;
  localparam int TS_W      = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int FRAC_BITS = 8;
  localparam int MUL1_W    = DIST_W + 10;
  localparam int N1_W      = MUL1_W + FRAC_BITS;
  localparam int SPD_W     = N1_W + 1;
  localparam int DIV_W     = SPD_W + 10;
  localparam int LIM_W     = CFG_W + FRAC_BITS;
  localparam int ACC_W     = LIM_W + 2;
  localparam int SM_W      = ACC_W + 2;
  localparam int OUT_W     = 17;
  localparam int CNT_W     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP   = 1'd1;

  localparam logic [CFG_W-1:0] MAX_ACCEL_RST = 16'd10000;
  localparam logic [CFG_W-1:0] MAX_GAP_RST   = 16'd1000;

  localparam logic [SQ_W-1:0]  RT_BIT0  = SQ_W'(1) << (SQ_W - 2);
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [SM_W-1:0]  SM_RND   = SM_W'(3);

  typedef logic signed [COORD_W-1:0] coord_t;

  function automatic logic [COORD_W-1:0] coord_mag(coord_t v);
    logic [COORD_W-1:0] u;
    u = v;
    return v[COORD_W-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

`default_nettype wire

/* src/ntra_in_if.sv */
// Input channel of the nearest-target radial acceleration core.
// Carries one radar frame per transaction; depends on ntra_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ntra_in_if
  import ntra_pkg::*;
();
  logic              valid;
  logic              ready;
  coord_t            target0_x;
  coord_t            target0_y;
  logic              target0_active;
  coord_t            target1_x;
  coord_t            target1_y;
  logic              target1_active;
  coord_t            target2_x;
  coord_t            target2_y;
  logic              target2_active;
  logic [TS_W-1:0]   timestamp_ms;

  modport source (
    output valid, target0_x, target0_y, target0_active,
    output target1_x, target1_y, target1_active,
    output target2_x, target2_y, target2_active, timestamp_ms,
    input  ready
  );

  modport sink (
    input  valid, target0_x, target0_y, target0_active,
    input  target1_x, target1_y, target1_active,
    input  target2_x, target2_y, target2_active, timestamp_ms,
    output ready
  );
endinterface

`default_nettype wire

/* src/ntra_out_if.sv */
// Result channel of the nearest-target radial acceleration core.
// Carries one acceleration value per transaction; depends on ntra_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ntra_out_if
  import ntra_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  radial_accel;

  modport source (output valid, radial_accel, input ready);
  modport sink (input valid, radial_accel, output ready);
endinterface

`default_nettype wire

/* src/nearest_target_radial_acceleration_core.sv */
// Nearest-target radial acceleration core, top level.
// Depends on ntra_pkg, ntra_in_if, ntra_out_if and the assertion macro header.
//
// One transaction per radar frame in, one acceleration result out. Squaring, square root
// and division are bit-serial: three lane squarers run first, the nearest active target is
// chosen next, then the integer square root is taken, and a shared restoring divider
// produces one quotient bit per cycle, first for the speed and then for the acceleration.
// A frame that re-seeds the tracker ends after the square root, a frame with no active
// target after the selection. The result then waits until the output register is free.
// The next frame is accepted as soon as the result has been moved to the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_target_radial_acceleration_core_defines.svh"

module nearest_target_radial_acceleration_core
  import ntra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata,
  ntra_in_if.sink               in_chan,
  ntra_out_if.source            out_chan
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SELECT,
    ST_SQRT,
    ST_DECIDE,
    ST_NUM1,
    ST_DIV,
    ST_SPEED,
    ST_DIFF2,
    ST_MAG2,
    ST_NUM2,
    ST_CLAMP,
    ST_SMOOTH,
    ST_ROUND,
    ST_OUT
  } state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      cnt_r;

  logic [CFG_W-1:0]      max_accel_r;
  logic [CFG_W-1:0]      max_gap_r;

  logic                  tracking_r;
  logic [TGT_IW-1:0]     tracked_idx_r;
  logic [DIST_W-1:0]     last_dist_r;
  logic [SPD_W-1:0]      last_speed_r;
  logic [ACC_W-1:0]      smooth_r;
  logic [TS_W-1:0]       last_time_r;

  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_accel_r;

  logic [NUM_TGT-1:0]    active_r;
  logic [TS_W-1:0]       now_r;
  logic [TS_W-1:0]       elapsed_r;
  logic [SQ_W-1:0]       sq_mcx_r [NUM_TGT];
  logic [SQ_W-1:0]       sq_mcy_r [NUM_TGT];
  logic [COORD_W-1:0]    sq_mpx_r [NUM_TGT];
  logic [COORD_W-1:0]    sq_mpy_r [NUM_TGT];
  logic [SQ_W-1:0]       sq_acc_r [NUM_TGT];
  logic                  found_r;
  logic [SQ_W-1:0]       best_sq_r;
  logic [TGT_IW-1:0]     best_idx_r;
  logic [SQ_W-1:0]       rt_rem_r;
  logic [SQ_W-1:0]       rt_res_r;
  logic [SQ_W-1:0]       rt_bit_r;
  logic [DIST_W:0]       diff1_r;
  logic [DIV_W-1:0]      dv_q_r;
  logic [CFG_W-1:0]      dv_rem_r;
  logic                  dv_neg_r;
  logic                  dv_pass_r;
  logic [SPD_W-1:0]      speed_r;
  logic [SPD_W:0]        sd_r;
  logic [SPD_W-1:0]      sdmag_r;
  logic [LIM_W:0]        accel_r;
  logic [OUT_W-1:0]      res_r;

  logic [COORD_W-1:0]    in_mag_x [NUM_TGT];
  logic [COORD_W-1:0]    in_mag_y [NUM_TGT];
  logic [NUM_TGT-1:0]    in_act;
  logic                  in_accept;
  logic [SQ_W-1:0]       sq_add [NUM_TGT];
  logic [TGT_IW-1:0]     sel_idx;
  logic                  sel_take;
  logic                  sel_found;
  logic                  sel_last;
  logic [SQ_W-1:0]       rt_try;
  logic                  rt_ge;
  logic [DIST_W-1:0]     root_dist;
  logic                  reseed;
  logic [DIST_W:0]       diff1_neg;
  logic [DIST_W-1:0]     diff1_mag;
  logic [MUL1_W-1:0]     num1_mul;
  logic [CFG_W:0]        dv_shift;
  logic [CFG_W:0]        dv_sub;
  logic                  dv_ge;
  logic [SPD_W-1:0]      q1_ext;
  logic [SPD_W:0]        sd_neg;
  logic [DIV_W-1:0]      num2_mul;
  logic [LIM_W-1:0]      lim;
  logic [LIM_W-1:0]      amag;
  logic [SM_W-1:0]       sm_old;
  logic [SM_W-1:0]       sm_new;
  logic [SM_W-1:0]       sm_sum;
  logic [SM_W-1:0]       sm_adj;
  logic [ACC_W-1:0]      rd_mag;
  logic [ACC_W-1:0]      rd_sum;
  logic [OUT_W-1:0]      rd_out;
  logic                  out_free;

  assign in_mag_x[0] = coord_mag(in_chan.target0_x);
  assign in_mag_y[0] = coord_mag(in_chan.target0_y);
  assign in_mag_x[1] = coord_mag(in_chan.target1_x);
  assign in_mag_y[1] = coord_mag(in_chan.target1_y);
  assign in_mag_x[2] = coord_mag(in_chan.target2_x);
  assign in_mag_y[2] = coord_mag(in_chan.target2_y);
  assign in_act = {in_chan.target2_active, in_chan.target1_active, in_chan.target0_active};

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_accept     = in_chan.valid && (state_r == ST_IDLE);

  always_comb begin
    for (int k = 0; k < NUM_TGT; k++) begin
      sq_add[k] = sq_acc_r[k] + (sq_mpx_r[k][0] ? sq_mcx_r[k] : '0)
                              + (sq_mpy_r[k][0] ? sq_mcy_r[k] : '0);
    end
  end

  assign sel_idx   = cnt_r[TGT_IW-1:0];
  assign sel_take  = active_r[sel_idx] && (!found_r || (sq_acc_r[sel_idx] < best_sq_r));
  assign sel_found = found_r || sel_take;
  assign sel_last  = (sel_idx == TGT_IW'(NUM_TGT - 1));

  assign rt_try    = rt_res_r + rt_bit_r;
  assign rt_ge     = (rt_rem_r >= rt_try);
  assign root_dist = rt_res_r[DIST_W-1:0];

  assign reseed = !tracking_r || (best_idx_r != tracked_idx_r) || (elapsed_r == '0) ||
                  (elapsed_r > TS_W'(max_gap_r));

  // A product by 1000 is formed as x*1024 - x*16 - x*8.
  assign diff1_neg = ~diff1_r + 1'b1;
  assign diff1_mag = diff1_r[DIST_W] ? diff1_neg[DIST_W-1:0] : diff1_r[DIST_W-1:0];
  assign num1_mul  = (MUL1_W'(diff1_mag) << 10) - (MUL1_W'(diff1_mag) << 4)
                   - (MUL1_W'(diff1_mag) << 3);

  assign dv_shift = {dv_rem_r, dv_q_r[DIV_W-1]};
  assign dv_sub   = dv_shift - {1'b0, elapsed_r[CFG_W-1:0]};
  assign dv_ge    = (dv_shift >= {1'b0, elapsed_r[CFG_W-1:0]});

  assign q1_ext   = SPD_W'(dv_q_r[N1_W-1:0]);
  assign sd_neg   = ~sd_r + 1'b1;
  assign num2_mul = (DIV_W'(sdmag_r) << 10) - (DIV_W'(sdmag_r) << 4)
                  - (DIV_W'(sdmag_r) << 3);

  assign lim  = {max_accel_r, {FRAC_BITS{1'b0}}};
  assign amag = (dv_q_r > DIV_W'(lim)) ? lim : dv_q_r[LIM_W-1:0];

  // The smoothed value is (3*old + new)/4, truncated toward zero.
  assign sm_old = {{(SM_W-ACC_W){smooth_r[ACC_W-1]}}, smooth_r};
  assign sm_new = {{(SM_W-LIM_W-1){accel_r[LIM_W]}}, accel_r};
  assign sm_sum = (sm_old << 1) + sm_old + sm_new;
  assign sm_adj = sm_sum[SM_W-1] ? (sm_sum + SM_RND) : sm_sum;

  assign rd_mag = smooth_r[ACC_W-1] ? (~smooth_r + 1'b1) : smooth_r;
  assign rd_sum = rd_mag + RND_HALF;
  assign rd_out = smooth_r[ACC_W-1] ? (~rd_sum[FRAC_BITS +: OUT_W] + 1'b1)
                                    : rd_sum[FRAC_BITS +: OUT_W];

  assign out_free = !out_valid_r || out_chan.ready;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.radial_accel = out_accel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      max_accel_r   <= MAX_ACCEL_RST;
      max_gap_r     <= MAX_GAP_RST;
      tracking_r    <= 1'b0;
      tracked_idx_r <= '0;
      last_dist_r   <= '0;
      last_speed_r  <= '0;
      smooth_r      <= '0;
      last_time_r   <= '0;
      out_valid_r   <= 1'b0;
      out_accel_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_MAX_ACCEL: max_accel_r <= cfg_wdata;
          REG_MAX_GAP:   max_gap_r   <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_chan.ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            cnt_r   <= CNT_W'(COORD_W);
            state_r <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_r <= ST_SELECT;
          end
        end
        ST_SELECT: begin
          if (sel_last) begin
            if (!sel_found) begin
              tracking_r <= 1'b0;
              smooth_r   <= '0;
              state_r    <= ST_OUT;
            end else begin
              cnt_r   <= CNT_W'(SQ_W / 2);
              state_r <= ST_SQRT;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_SQRT: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (reseed) begin
            tracking_r    <= 1'b1;
            tracked_idx_r <= best_idx_r;
            last_dist_r   <= root_dist;
            last_speed_r  <= '0;
            smooth_r      <= '0;
            last_time_r   <= now_r;
            state_r       <= ST_OUT;
          end else begin
            state_r <= ST_NUM1;
          end
        end
        ST_NUM1: begin
          cnt_r   <= CNT_W'(N1_W);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_r <= dv_pass_r ? ST_CLAMP : ST_SPEED;
          end
        end
        ST_SPEED: state_r <= ST_DIFF2;
        ST_DIFF2: state_r <= ST_MAG2;
        ST_MAG2:  state_r <= ST_NUM2;
        ST_NUM2: begin
          cnt_r   <= CNT_W'(DIV_W);
          state_r <= ST_DIV;
        end
        ST_CLAMP: begin
          last_dist_r  <= root_dist;
          last_speed_r <= speed_r;
          last_time_r  <= now_r;
          state_r      <= ST_SMOOTH;
        end
        ST_SMOOTH: begin
          smooth_r <= sm_adj[ACC_W+1:2];
          state_r  <= ST_ROUND;
        end
        ST_ROUND: state_r <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_accel_r <= res_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          active_r  <= in_act;
          now_r     <= in_chan.timestamp_ms;
          elapsed_r <= in_chan.timestamp_ms - last_time_r;
          found_r   <= 1'b0;
          for (int k = 0; k < NUM_TGT; k++) begin
            sq_mcx_r[k] <= SQ_W'(in_mag_x[k]);
            sq_mcy_r[k] <= SQ_W'(in_mag_y[k]);
            sq_mpx_r[k] <= in_mag_x[k];
            sq_mpy_r[k] <= in_mag_y[k];
            sq_acc_r[k] <= '0;
          end
        end
      end
      ST_SQUARE: begin
        for (int k = 0; k < NUM_TGT; k++) begin
          sq_acc_r[k] <= sq_add[k];
          sq_mcx_r[k] <= sq_mcx_r[k] << 1;
          sq_mcy_r[k] <= sq_mcy_r[k] << 1;
          sq_mpx_r[k] <= sq_mpx_r[k] >> 1;
          sq_mpy_r[k] <= sq_mpy_r[k] >> 1;
        end
      end
      ST_SELECT: begin
        if (sel_take) begin
          found_r    <= 1'b1;
          best_sq_r  <= sq_acc_r[sel_idx];
          best_idx_r <= sel_idx;
        end
        if (sel_last) begin
          rt_rem_r <= sel_take ? sq_acc_r[sel_idx] : best_sq_r;
          rt_res_r <= '0;
          rt_bit_r <= RT_BIT0;
          res_r    <= '0;
        end
      end
      ST_SQRT: begin
        rt_rem_r <= rt_ge ? (rt_rem_r - rt_try) : rt_rem_r;
        rt_res_r <= (rt_res_r >> 1) + (rt_ge ? rt_bit_r : '0);
        rt_bit_r <= rt_bit_r >> 2;
      end
      ST_DECIDE: begin
        diff1_r <= {1'b0, root_dist} - {1'b0, last_dist_r};
        res_r   <= '0;
      end
      ST_NUM1: begin
        dv_q_r    <= {num1_mul, {FRAC_BITS{1'b0}}, {(DIV_W-N1_W){1'b0}}};
        dv_rem_r  <= '0;
        dv_neg_r  <= diff1_r[DIST_W];
        dv_pass_r <= 1'b0;
      end
      ST_DIV: begin
        dv_rem_r <= dv_ge ? dv_sub[CFG_W-1:0] : dv_shift[CFG_W-1:0];
        dv_q_r   <= {dv_q_r[DIV_W-2:0], dv_ge};
      end
      ST_SPEED: begin
        speed_r <= dv_neg_r ? (~q1_ext + 1'b1) : q1_ext;
      end
      ST_DIFF2: begin
        sd_r <= {speed_r[SPD_W-1], speed_r} - {last_speed_r[SPD_W-1], last_speed_r};
      end
      ST_MAG2: begin
        dv_neg_r <= sd_r[SPD_W];
        sdmag_r  <= sd_r[SPD_W] ? sd_neg[SPD_W-1:0] : sd_r[SPD_W-1:0];
      end
      ST_NUM2: begin
        dv_q_r    <= num2_mul;
        dv_rem_r  <= '0;
        dv_pass_r <= 1'b1;
      end
      ST_CLAMP: begin
        accel_r <= dv_neg_r ? (~{1'b0, amag} + 1'b1) : {1'b0, amag};
      end
      ST_ROUND: begin
        res_r <= rd_out;
      end
      default: ;
    endcase
  end

  `NTRA_ASSERT_SAME(a_div_rem_below_divisor, state_r == ST_DIV,
    dv_rem_r < elapsed_r[CFG_W-1:0], "divider remainder reached the divisor")
  `NTRA_ASSERT_SAME(a_root_bit_onehot, state_r == ST_SQRT,
    $onehot(rt_bit_r), "square root trial bit is not one-hot")
  `NTRA_ASSERT_NEXT(a_accept_starts_squaring, in_accept,
    state_r == ST_SQUARE, "accepted transaction did not start the squarers")
  `NTRA_ASSERT_SAME(a_nonzero_needs_tracking, $rose(out_valid_r) && (out_accel_r != '0),
    tracking_r, "nonzero result while the tracker is not tracking")

endmodule

`default_nettype wire
